### src/rfc_pkg.sv
`default_nettype none

package rfc_pkg;

  localparam logic [7:0] HDR_FIRST  = 8'hAA;
  localparam logic [7:0] HDR_SECOND = 8'h75;

  // byte position within a frame, saturating at POS_BODY
  localparam logic [1:0] POS_FIRST  = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_CMD    = 2'd2;
  localparam logic [1:0] POS_BODY   = 2'd3;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_HDR  = 2'd1,
    ST_CSUM = 2'd2,
    ST_CMD  = 2'd3
  } rfc_status_t;

  localparam logic [2:0] CLS_BASIC  = 3'd0;
  localparam logic [2:0] CLS_SEARCH = 3'd1;
  localparam logic [2:0] CLS_SET    = 3'd2;
  localparam logic [2:0] CLS_TEST   = 3'd3;
  localparam logic [2:0] CLS_PARAM  = 3'd4;

  typedef struct packed {
    logic       known;
    logic [2:0] cls;
    logic [2:0] off;
  } rfc_lookup_t;

  typedef struct packed {
    rfc_status_t status;
    logic [7:0]  command_code;
    logic [2:0]  command_class;
    logic [2:0]  command_offset;
  } rfc_result_t;

  // command table: 00-07, 08 09 10-15, 82-84 C2-C4, E0-E5, D0
  function automatic rfc_lookup_t cmd_lookup(input logic [7:0] code);
    rfc_lookup_t r;
    r = '0;
    unique case (code) inside
      [8'h00:8'h07]: begin
        r.known = 1'b1; r.cls = CLS_BASIC;  r.off = code[2:0];
      end
      [8'h08:8'h09]: begin
        r.known = 1'b1; r.cls = CLS_SEARCH; r.off = {2'b00, code[0]};
      end
      [8'h10:8'h15]: begin
        r.known = 1'b1; r.cls = CLS_SEARCH; r.off = code[2:0] + 3'd2;
      end
      [8'h82:8'h84]: begin
        r.known = 1'b1; r.cls = CLS_SET;    r.off = code[2:0] - 3'd2;
      end
      [8'hC2:8'hC4]: begin
        r.known = 1'b1; r.cls = CLS_SET;    r.off = code[2:0] + 3'd1;
      end
      [8'hE0:8'hE5]: begin
        r.known = 1'b1; r.cls = CLS_TEST;   r.off = code[2:0];
      end
      8'hD0: begin
        r.known = 1'b1; r.cls = CLS_PARAM;  r.off = 3'd0;
      end
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### src/rfc_if.sv
`default_nettype none

interface rfc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  logic       from_serial;

  modport source (output valid, output data_byte, output is_last, output from_serial,
                  input ready);
  modport sink (input valid, input data_byte, input is_last, input from_serial,
                output ready);
endinterface

interface rfc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] command_code;
  logic [2:0] command_class;
  logic [2:0] command_offset;

  modport source (output valid, output status, output command_code,
                  output command_class, output command_offset, input ready);
  modport sink (input valid, input status, input command_code,
                input command_class, input command_offset, output ready);
endinterface

`default_nettype wire

### src/rfc_frame_track.sv
`default_nettype none

module rfc_frame_track (
  input  wire                  clk,
  input  wire                  rst_n,
  rfc_in_if.sink               in_ch,
  output logic                 res_valid,
  input  wire                  res_ready,
  output rfc_pkg::rfc_result_t res
);
  import rfc_pkg::*;

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       s1_serial_r;

  // per-frame state
  logic [1:0] pos_r, pos_nxt;
  logic [7:0] xor_r, xor_nxt;
  logic       hdr_bad_r, hdr_bad_nxt;
  logic [7:0] cmd_r, cmd_nxt;

  logic        in_fire;
  logic        adv;
  logic        hdr_bad_now;
  logic        capture;
  logic [7:0]  cmd_now;
  rfc_lookup_t lk;
  rfc_status_t status;

  // a non-last byte never waits on the result side
  assign adv          = s1_valid_r && (!s1_last_r || res_ready);
  assign in_ch.ready  = !s1_valid_r || adv;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign res_valid    = s1_valid_r && s1_last_r;

  always_comb begin
    hdr_bad_now = hdr_bad_r
                  || (pos_r == POS_FIRST  && s1_byte_r != HDR_FIRST)
                  || (pos_r == POS_SECOND && s1_byte_r != HDR_SECOND);
    capture = (pos_r == POS_FIRST && !s1_serial_r) || (pos_r == POS_CMD && s1_serial_r);
    cmd_now = capture ? s1_byte_r : cmd_r;
    lk      = cmd_lookup(cmd_now);

    if (s1_serial_r && (pos_r == POS_FIRST || pos_r == POS_SECOND || hdr_bad_now)) begin
      status = ST_HDR;
    end else if (s1_serial_r && xor_r != s1_byte_r) begin
      status = ST_CSUM;
    end else if (!lk.known) begin
      status = ST_CMD;
    end else begin
      status = ST_OK;
    end

    res.status         = status;
    res.command_code   = cmd_now;
    res.command_class  = (status == ST_OK) ? lk.cls : 3'd0;
    res.command_offset = (status == ST_OK) ? lk.off : 3'd0;
  end

  always_comb begin
    s1_valid_nxt = in_fire || (s1_valid_r && !adv);
    pos_nxt      = pos_r;
    xor_nxt      = xor_r;
    hdr_bad_nxt  = hdr_bad_r;
    cmd_nxt      = cmd_r;
    if (adv) begin
      if (s1_last_r) begin
        pos_nxt     = POS_FIRST;
        xor_nxt     = '0;
        hdr_bad_nxt = 1'b0;
        cmd_nxt     = '0;
      end else begin
        pos_nxt     = (pos_r == POS_BODY) ? POS_BODY : pos_r + 2'd1;
        xor_nxt     = xor_r ^ s1_byte_r;
        hdr_bad_nxt = hdr_bad_now;
        cmd_nxt     = cmd_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      pos_r      <= POS_FIRST;
      xor_r      <= '0;
      hdr_bad_r  <= 1'b0;
      cmd_r      <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      pos_r      <= pos_nxt;
      xor_r      <= xor_nxt;
      hdr_bad_r  <= hdr_bad_nxt;
      cmd_r      <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r   <= in_ch.data_byte;
      s1_last_r   <= in_ch.is_last;
      s1_serial_r <= in_ch.from_serial;
    end
  end

`ifndef SYNTHESIS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && s1_last_r) |=> (pos_r == POS_FIRST && xor_r == 8'h00 && !hdr_bad_r
                            && cmd_r == 8'h00))
    else $error("frame state not cleared after last byte");

  a_pos_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_last_r) |=> (pos_r != POS_FIRST))
    else $error("byte position did not advance");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status != ST_OK) |-> (res.command_class == 3'd0
                                            && res.command_offset == 3'd0))
    else $error("failed frame carries class or offset");

  a_ok_class: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_OK) |-> (res.command_class <= CLS_PARAM))
    else $error("class out of range on good frame");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(s1_byte_r) && $stable(pos_r)))
    else $error("stalled byte lost");
`endif

endmodule

`default_nettype wire

### src/rfc_result_reg.sv
`default_nettype none

module rfc_result_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 res_valid,
  output logic                res_ready,
  input  wire rfc_pkg::rfc_result_t res,
  rfc_out_if.source           out_ch
);
  import rfc_pkg::*;

  logic        out_valid_r, out_valid_nxt;
  rfc_result_t out_r;
  logic        load;

  assign res_ready = !out_valid_r || out_ch.ready;
  assign load      = res_valid && res_ready;

  always_comb begin
    out_valid_nxt = load || (out_valid_r && !out_ch.ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.command_code   = out_r.command_code;
  assign out_ch.command_class  = out_r.command_class;
  assign out_ch.command_offset = out_r.command_offset;

endmodule

`default_nettype wire

### src/recorder_frame_checker_unit.sv
// Recorder frame checker.
// in_ch carries one frame byte per transaction (data_byte, is_last, from_serial);
// out_ch carries one result per frame (status, command_code, command_class,
// command_offset), issued for the transaction that has is_last set.
// Both channels use valid/ready; a transaction completes when both are high.
// Throughput: one byte per clock while in_ch.ready is high. Each byte is
// captured in an input register, checked by combinational logic (header
// compare, running XOR, command table), and the frame result of a last
// byte is then loaded into an output register that drives out_ch.
// Stall: while out_ch is held off with a result pending, bytes that do not end
// a frame keep flowing; a second last byte waits in the input register, and
// in_ch.ready drops only then.
// Reset (rst_n low at a clock edge) empties both registers and starts a new
// frame at byte zero with the running XOR cleared.
`default_nettype none

module recorder_frame_checker_unit (
  input  wire       clk,
  input  wire       rst_n,
  rfc_in_if.sink    in_ch,
  rfc_out_if.source out_ch
);
  import rfc_pkg::*;

  logic        res_valid;
  logic        res_ready;
  rfc_result_t res;

  rfc_frame_track u_track (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  rfc_result_reg u_result (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import rfc_pkg::*;

  localparam int RANDOM_BYTES     = 1600;
  localparam int LONG_HOLD_CYCLES = 80;
  localparam int WATCHDOG_LIMIT   = 1000;
  localparam int DRAIN_CYCLES     = 8;
  localparam int MAX_PRINTED      = 100;
  localparam int NUM_CODES        = 29;

  localparam logic [7:0] KNOWN_CODES [NUM_CODES] = '{
    8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07,
    8'h08, 8'h09, 8'h10, 8'h11, 8'h12, 8'h13, 8'h14, 8'h15,
    8'h82, 8'h83, 8'h84, 8'hC2, 8'hC3, 8'hC4,
    8'hE0, 8'hE1, 8'hE2, 8'hE3, 8'hE4, 8'hE5,
    8'hD0
  };

  // one frame byte plus an optional hand-written expectation for its result
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        serial;
    logic        typed;
    rfc_result_t res;
  } frame_byte_t;

  localparam rfc_result_t NO_RES = '{ST_OK, 8'h00, 3'd0, 3'd0};

  localparam int DIRECTED_ROWS = 24;
  localparam frame_byte_t DIRECTED [DIRECTED_ROWS] = '{
    // one-byte wireless frames
    '{8'h00, 1'b1, 1'b0, 1'b1, '{ST_OK,  8'h00, CLS_BASIC, 3'd0}},
    '{8'hD0, 1'b1, 1'b0, 1'b1, '{ST_OK,  8'hD0, CLS_PARAM, 3'd0}},
    '{8'hFF, 1'b1, 1'b0, 1'b1, '{ST_CMD, 8'hFF, CLS_BASIC, 3'd0}},
    // serial frames too short for a header
    '{8'hAA, 1'b1, 1'b1, 1'b1, '{ST_HDR, 8'h00, CLS_BASIC, 3'd0}},
    '{8'hAA, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h75, 1'b1, 1'b1, 1'b1, '{ST_HDR, 8'h00, CLS_BASIC, 3'd0}},
    // good serial frame
    '{8'hAA, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h75, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hE5, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h3A, 1'b1, 1'b1, 1'b1, '{ST_OK, 8'hE5, CLS_TEST, 3'd5}},
    // bad first header byte, checksum right
    '{8'hAB, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h75, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h01, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hDF, 1'b1, 1'b1, 1'b1, '{ST_HDR, 8'h01, CLS_BASIC, 3'd0}},
    // bad checksum
    '{8'hAA, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h75, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h15, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b1, 1'b1, '{ST_CSUM, 8'h15, CLS_BASIC, 3'd0}},
    // unknown command, checksum right
    '{8'hAA, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h75, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'hFF, 1'b0, 1'b1, 1'b0, NO_RES},
    '{8'h20, 1'b1, 1'b1, 1'b1, '{ST_CMD, 8'hFF, CLS_BASIC, 3'd0}},
    // wireless frame with a trailing byte
    '{8'h82, 1'b0, 1'b0, 1'b0, NO_RES},
    '{8'h00, 1'b1, 1'b0, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  rfc_in_if  in_ch ();
  rfc_out_if out_ch ();

  recorder_frame_checker_unit DUT (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // predictor state for the frame in progress
  logic [1:0]  frame_pos;
  logic [7:0]  frame_xor;
  logic        hdr_bad;
  logic [7:0]  cmd_byte;

  rfc_result_t expected_frame_results [$];
  logic        drv_typed;
  rfc_result_t drv_res;
  int          error_count;
  int          bytes_sent;
  int          idle_cycles;
  bit          long_hold;

  task report_mismatch(input string msg);
    // keep the log bounded on a badly broken build
    if (error_count < MAX_PRINTED)
      $display("ERROR %0t: %s", $time, msg);
    error_count++;
  endtask

  task predict_frame_byte(input logic [7:0] b, input logic last, input logic serial,
                          output bit produced, output rfc_result_t res);
    logic [1:0] pos;
    logic [7:0] xor_prior;
    bit         known;
    logic [2:0] cls;
    logic [2:0] off;
    int         k;
    pos = frame_pos;
    xor_prior = frame_xor;
    if (pos == POS_FIRST && b != HDR_FIRST) hdr_bad = 1'b1;
    if (pos == POS_SECOND && b != HDR_SECOND) hdr_bad = 1'b1;
    if ((pos == POS_FIRST && !serial) || (pos == POS_CMD && serial)) cmd_byte = b;
    frame_xor = frame_xor ^ b;
    if (frame_pos != POS_BODY) frame_pos = frame_pos + 2'd1;
    produced = last;
    res = NO_RES;
    if (last) begin
      known = 1'b0;
      cls = 3'd0;
      off = 3'd0;
      for (k = 0; k < NUM_CODES; k++) begin
        if (KNOWN_CODES[k] == cmd_byte) begin
          known = 1'b1;
          if (k < 8) begin
            cls = CLS_BASIC;  off = 3'(k);
          end else if (k < 16) begin
            cls = CLS_SEARCH; off = 3'(k - 8);
          end else if (k < 22) begin
            cls = CLS_SET;    off = 3'(k - 16);
          end else if (k < 28) begin
            cls = CLS_TEST;   off = 3'(k - 22);
          end else begin
            cls = CLS_PARAM;  off = 3'd0;
          end
        end
      end
      res.command_code = cmd_byte;
      // header beats checksum beats command
      if (serial && (pos < POS_CMD || hdr_bad)) begin
        res.status = ST_HDR;
      end else if (serial && xor_prior != b) begin
        res.status = ST_CSUM;
      end else if (!known) begin
        res.status = ST_CMD;
      end else begin
        res.status = ST_OK;
        res.command_class = cls;
        res.command_offset = off;
      end
      frame_pos = POS_FIRST;
      frame_xor = 8'h00;
      hdr_bad = 1'b0;
      cmd_byte = 8'h00;
    end
  endtask

  task send_byte(input frame_byte_t row, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.data_byte   <= row.data;
    in_ch.is_last     <= row.last;
    in_ch.from_serial <= row.serial;
    drv_typed         <= row.typed;
    drv_res           <= row.res;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    bytes_sent++;
  endtask

  task send_random_frame();
    logic [7:0] frame_bytes [$];
    logic [7:0] cmd;
    logic [7:0] csum;
    bit         serial;
    bit         no_gap;
    int         body_len;
    serial = 1'($urandom_range(0, 1));
    no_gap = ($urandom_range(0, 3) == 0);
    cmd = ($urandom_range(0, 3) != 0) ? KNOWN_CODES[$urandom_range(0, NUM_CODES - 1)]
                                      : 8'($urandom);
    // mostly short bodies, now and then a long one
    body_len = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 24) : $urandom_range(0, 3);
    frame_bytes.delete();
    if (serial) begin
      frame_bytes = '{HDR_FIRST, HDR_SECOND, cmd};
      if ($urandom_range(0, 19) == 0)
        frame_bytes[$urandom_range(0, 1)] = 8'($urandom);
    end else begin
      frame_bytes = '{cmd};
    end
    repeat (body_len) frame_bytes.push_back(8'($urandom));
    if (serial) begin
      csum = 8'h00;
      foreach (frame_bytes[i]) csum = csum ^ frame_bytes[i];
      if ($urandom_range(0, 9) == 0) csum = csum ^ 8'($urandom_range(1, 255));
      frame_bytes.push_back(csum);
    end
    foreach (frame_bytes[i])
      send_byte('{frame_bytes[i], (i == frame_bytes.size() - 1), serial, 1'b0, NO_RES},
                no_gap);
  endtask

  // short junk: random channel per byte, headers now and then, random frame ends
  task send_noise();
    int         n;
    int         i;
    logic [7:0] b;
    n = $urandom_range(1, 6);
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: b = HDR_FIRST;
        1: b = HDR_SECOND;
        default: b = 8'($urandom);
      endcase
      send_byte('{b, (i == n - 1) || ($urandom_range(0, 3) == 0), 1'($urandom_range(0, 1)),
                  1'b0, NO_RES}, 1'b0);
    end
  endtask

  initial begin
    int hold_count;
    int j;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.is_last = 1'b0;
    in_ch.from_serial = 1'b0;
    drv_typed = 1'b0;
    drv_res = NO_RES;
    error_count = 0;
    bytes_sent = 0;
    long_hold = 1'b0;
    hold_count = 0;
    frame_pos = POS_FIRST;
    frame_xor = 8'h00;
    hdr_bad = 1'b0;
    cmd_byte = 8'h00;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_byte(DIRECTED[i], 1'b0);

    while (bytes_sent < DIRECTED_ROWS + RANDOM_BYTES) begin
      if (hold_count < 2 && bytes_sent > 400 + 700 * hold_count) begin
        // back-to-back one-byte frames against a stalled output
        long_hold = 1'b1;
        hold_count++;
        for (j = 0; j < 16; j++)
          send_byte('{KNOWN_CODES[$urandom_range(0, NUM_CODES - 1)], 1'b1, 1'b0, 1'b0,
                      NO_RES}, 1'b1);
      end else if ($urandom_range(0, 99) < 85) begin
        send_random_frame();
      end else begin
        send_noise();
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_frame_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS recorder_frame_checker_unit");
    end else begin
      $display("FAIL recorder_frame_checker_unit");
    end
    $finish;
  end

  // result receiver
  initial begin
    int stall;
    int burst_left;
    out_ch.ready = 1'b0;
    burst_left = 0;
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end
      if (burst_left > 0) begin
        stall = 0;
        burst_left--;
      end else begin
        stall = $urandom_range(0, 6);
        if ($urandom_range(0, 15) == 0) burst_left = 20;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(rst_n && out_ch.valid && out_ch.ready));
    end
  end

  // predict on every accepted input transaction
  always @(posedge clk) begin
    bit          produced;
    rfc_result_t res;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      predict_frame_byte(in_ch.data_byte, in_ch.is_last, in_ch.from_serial, produced, res);
      if (produced) expected_frame_results.push_back(drv_typed ? drv_res : res);
    end
  end

  always @(posedge clk) begin
    rfc_result_t exp_res;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_frame_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d code=%02h",
                                  out_ch.status, out_ch.command_code));
      end else begin
        exp_res = expected_frame_results.pop_front();
        if (out_ch.status !== exp_res.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_ch.status, exp_res.status));
        if (out_ch.command_code !== exp_res.command_code)
          report_mismatch($sformatf("command_code %02h, want %02h",
                                    out_ch.command_code, exp_res.command_code));
        if (out_ch.command_class !== exp_res.command_class)
          report_mismatch($sformatf("command_class %0d, want %0d (code %02h)",
                                    out_ch.command_class, exp_res.command_class,
                                    exp_res.command_code));
        if (out_ch.command_offset !== exp_res.command_offset)
          report_mismatch($sformatf("command_offset %0d, want %0d (code %02h)",
                                    out_ch.command_offset, exp_res.command_offset,
                                    exp_res.command_code));
      end
    end
  end

  // watchdog: no transaction on either channel for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout at %0t, %0d results outstanding", $time,
               expected_frame_results.size());
      $display("FAIL recorder_frame_checker_unit");
      $finish;
    end
  end

  initial idle_cycles = 0;

endmodule
